[rtl/core/wsm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsm_pkg
// Shared types and codes of the wavetable synthesizer mixer: input modes,
// the command word passed from front to back, and the divider interface.
// ----------------------------------------------------------------------------
package wsm_pkg;

	// Input mode codes as they arrive on the stream
	localparam logic [2:0] MODE_TICK     = 3'd0;
	localparam logic [2:0] MODE_END      = 3'd1;
	localparam logic [2:0] MODE_TABLE    = 3'd2;
	localparam logic [2:0] MODE_VOLUME   = 3'd3;
	localparam logic [2:0] MODE_PAN      = 3'd4;
	localparam logic [2:0] MODE_VELOCITY = 3'd5;
	localparam logic [2:0] MODE_PITCH    = 3'd6;
	localparam logic [2:0] MODE_BEND     = 3'd7;

	// Voice address width for the largest voice array (16 tracks x 8 voices)
	localparam int VADDR_W = 7;

	// Divider operand widths
	localparam int DIVD_W = 32;
	localparam int DIVS_W = 18;

	typedef enum logic [2:0] {
		CMD_TICK,
		CMD_END,
		CMD_TABLE,
		CMD_VOLUME,
		CMD_PAN,
		CMD_VELOCITY,
		CMD_PITCH,
		CMD_BEND
	} cmd_kind_t;

	// Classified command; value already saturated or converted per kind
	typedef struct packed {
		cmd_kind_t           kind;
		logic [3:0]          track;
		logic [VADDR_W-1:0]  vaddr;
		logic [15:0]         value;
	} cmd_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quot;
		logic [DIVS_W-1:0] rem;
	} div_rsp_t;

endpackage

[rtl/core/wsm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsm_front
// Accepts input transactions, drops events to absent tracks or voices,
// converts arguments and queues commands for the back end.
// ----------------------------------------------------------------------------
module wsm_front #(
	parameter int TRACKS = 16,
	parameter int VOICES = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [23:0]     s_tdata,
	input  logic [2:0]      s_tuser,
	input  logic            en,
	output logic            cmd_valid,
	output wsm_pkg::cmd_t   cmd,
	input  logic            cmd_pop
);
	import wsm_pkg::*;

	logic [2:0]  mode;
	logic [3:0]  track;
	logic [2:0]  voice;
	logic [15:0] arg;
	logic [6:0]  a7;
	logic [7:0]  vaddr_full;
	logic        keep;
	logic        push;
	cmd_t        cmd_new;

	cmd_t        fifo_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign mode  = s_tuser;
	assign track = s_tdata[3:0];
	assign voice = s_tdata[6:4];
	assign arg   = s_tdata[22:7];
	assign a7    = (arg > 16'd127) ? 7'd127 : arg[6:0];
	assign vaddr_full = 8'(track) * 8'(VOICES) + 8'(voice);

	// Keep ticks and ends; drop events that address absent tracks or voices
	always_comb begin
		keep = 1'b1;
		if (mode != MODE_TICK && mode != MODE_END) begin
			if ({1'b0, track} >= 5'(TRACKS)) begin
				keep = 1'b0;
			end else if (mode == MODE_VELOCITY || mode == MODE_PITCH || mode == MODE_BEND) begin
				if ({1'b0, voice} >= 4'(VOICES)) begin
					keep = 1'b0;
				end
			end
		end
	end

	// Classify the transaction and convert its argument
	always_comb begin
		cmd_new.track = track;
		cmd_new.vaddr = vaddr_full[VADDR_W-1:0];
		unique case (mode)
			MODE_TICK: begin
				cmd_new.kind  = CMD_TICK;
				cmd_new.value = 16'd0;
			end
			MODE_END: begin
				cmd_new.kind  = CMD_END;
				cmd_new.value = 16'd0;
			end
			MODE_TABLE: begin
				cmd_new.kind  = CMD_TABLE;
				cmd_new.value = {15'd0, (arg != 16'd0)};
			end
			MODE_VOLUME: begin
				cmd_new.kind  = CMD_VOLUME;
				cmd_new.value = {9'd0, 7'(7'd127 - a7)};
			end
			MODE_PAN: begin
				cmd_new.kind  = CMD_PAN;
				cmd_new.value = {9'd0, 7'(a7 - 7'd64)};
			end
			MODE_VELOCITY: begin
				cmd_new.kind  = CMD_VELOCITY;
				cmd_new.value = {9'd0, a7};
			end
			MODE_PITCH: begin
				cmd_new.kind  = CMD_PITCH;
				cmd_new.value = {9'd0, a7};
			end
			default: begin
				cmd_new.kind  = CMD_BEND;
				cmd_new.value = arg;
			end
		endcase
	end

	assign s_tready  = en && (count_q != 2'd2);
	assign push      = s_tvalid && s_tready && keep;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];

	// Command queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_new;
		end
	end

	// Queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop && cmd_valid) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(cmd_pop && cmd_valid);
		end
	end

endmodule

[rtl/core/wsm_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsm_div
// Restoring unsigned divider, one quotient bit per cycle, shared by the
// sine table fill and the phase step computation.
// ----------------------------------------------------------------------------
module wsm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  wsm_pkg::div_req_t req,
	output wsm_pkg::div_rsp_t rsp
);
	import wsm_pkg::*;

	localparam int CNT_W = $clog2(DIVD_W);

	logic [DIVD_W-1:0] quo_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIVS_W:0]   trial;

	assign trial = {rem_q, quo_q[DIVD_W-1]};

	// Shift in one dividend bit and subtract where it fits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				quo_q  <= req.dividend;
				rem_q  <= '0;
				dvs_q  <= req.divisor;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (trial >= {1'b0, dvs_q}) begin
					rem_q <= DIVS_W'(trial - {1'b0, dvs_q});
					quo_q <= {quo_q[DIVD_W-2:0], 1'b1};
				end else begin
					rem_q <= trial[DIVS_W-1:0];
					quo_q <= {quo_q[DIVD_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

[rtl/core/wsm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsm_back
// Executes queued commands: track and voice updates, the phase step
// sequence, the per-voice mixing pipeline and the output register.
// ----------------------------------------------------------------------------
module wsm_back #(
	parameter int TRACKS = 16,
	parameter int VOICES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  wsm_pkg::cmd_t     cmd,
	output logic              cmd_pop,
	output logic              init_done,
	output wsm_pkg::div_req_t div_req,
	input  wsm_pkg::div_rsp_t div_rsp,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [15:0]       left_sample,
	output logic [15:0]       right_sample,
	output logic              is_end
);
	import wsm_pkg::*;

	localparam int NVOICE  = TRACKS * VOICES;
	localparam int VA_W    = (NVOICE > 1) ? $clog2(NVOICE) : 1;
	localparam int TW      = (TRACKS > 1) ? $clog2(TRACKS) : 1;
	localparam int KW      = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int PHASE_W = 27;
	localparam int SINE_N  = 1024;
	localparam int ACC_W   = 26;

	localparam logic [31:0] LN_SEMITONE = 32'h0EC98200;
	localparam logic [31:0] LN_STEP     = LN_SEMITONE >> 8;
	localparam int          OCT_SPAN    = 12 * 256;
	localparam int          OCT_MAX     = 10;
	localparam logic [15:0] NOTE_OFS    = 16'(3 * 256);
	localparam logic [31:0] STEP_OFS    = 32'((22 << 21) / 2205);
	localparam logic [17:0] SINE_DEN    = 18'd162005;

	// Division by 2205 << 6: drop six bits, then multiply by ceil(2^38 / 2205)
	// and keep bits 52:38; exact for any 26-bit operand
	localparam int          RECIP_SH    = 38;
	localparam logic [26:0] STEP_RECIP  = 27'd124661183;
	localparam logic [13:0] RECIP_LO    = STEP_RECIP[13:0];
	localparam logic [12:0] RECIP_HI    = STEP_RECIP[26:14];

	typedef enum logic [3:0] {
		ST_CLEAR, ST_SIN_C, ST_SIN_D, ST_SIN_W, ST_IDLE, ST_TICK, ST_DRAIN,
		ST_OUT, ST_NRD, ST_OCT, ST_X, ST_EXP, ST_EXP_D, ST_EXP_W, ST_BASE, ST_BASE_W
	} state_t;

	function automatic logic [15:0] sat16(input logic signed [ACC_W-1:0] v);
		logic [15:0] r;
		if (v > ACC_W'(32767)) begin
			r = 16'h7FFF;
		end else if (v < -ACC_W'(32768)) begin
			r = 16'h8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	state_t state_q;

	// Control and sequencing registers
	logic [VA_W-1:0]   clr_q;
	logic [9:0]        j_q;
	logic [25:0]       c_q;
	logic              init_done_q;
	cmd_t              cmd_q;
	logic [VA_W-1:0]   lin_q;
	logic [TW-1:0]     ti_q;
	logic [KW-1:0]     k_q;
	logic              end_pend_q;
	logic [15:0]       q_q;
	logic [3:0]        oct_q;
	logic [11:0]       rem12_q;
	logic [31:0]       x_q;
	logic [31:0]       e_q;
	logic [31:0]       t_q;
	logic [31:0]       prod_q;
	logic [7:0]        kdiv_q;
	logic [31:0]       m_q;
	logic [39:0]       plo_q;
	logic [38:0]       phi_q;
	logic              out_valid_q;
	logic [15:0]       left_q;
	logic [15:0]       right_q;
	logic              is_end_q;

	// Track registers
	logic              table_q [TRACKS];
	logic [6:0]        atten_q [TRACKS];
	logic [6:0]        pan_q   [TRACKS];

	// Voice memories
	logic [PHASE_W-1:0] phase_mem_q [NVOICE];
	logic [31:0]        step_mem_q  [NVOICE];
	logic [6:0]         vel_mem_q   [NVOICE];
	logic [6:0]         note_mem_q  [NVOICE];
	logic [15:0]        bend_mem_q  [NVOICE];
	logic [14:0]        sine_mem_q  [SINE_N];

	logic [PHASE_W-1:0] phase_s1;
	logic [31:0]        step_s1;
	logic [6:0]         vel_s1;
	logic [6:0]         note_rd_q;
	logic [15:0]        bend_rd_q;
	logic [14:0]        sine_s2;

	// Mixing pipeline
	logic               v_s1, v_s2, v_s3, v_s4;
	logic [VA_W-1:0]    addr_s1;
	logic               tsel_s1, tsel_s2;
	logic [6:0]         atten_s1;
	logic [6:0]         pan_s1;
	logic               neg_s2;
	logic [15:0]        saw_s2;
	logic [6:0]         vel_s2;
	logic signed [15:0] lvol_s2, rvol_s2, lvol_s3, rvol_s3;
	logic signed [16:0] amp_s3;
	logic signed [18:0] pl_s4, pr_s4;
	logic signed [ACC_W-1:0] acc_l_q, acc_r_q;

	// Combinational helpers
	logic               clearing;
	logic               issue;
	logic               tick_start;
	logic               last_voice;
	logic [VA_W-1:0]    rd_addr;
	logic [VA_W-1:0]    evt_addr;
	logic [VA_W-1:0]    cur_addr;
	logic [TW-1:0]      evt_track;
	logic               phase_we, step_we, vel_we, note_we, bend_we;
	logic [VA_W-1:0]    phase_wa, vel_wa, evt_wa;
	logic [PHASE_W-1:0] phase_wd;
	logic [31:0]        step_wd;
	logic [6:0]         vel_wd;
	logic [6:0]         note_wd;
	logic [15:0]        bend_wd;
	logic               sine_we;
	logic [10:0]        idx_s1;
	logic [25:0]        saw_prod;
	logic signed [16:0] saw_val;
	logic signed [8:0]  lpan, rpan, gain;
	logic signed [17:0] lvol_full, rvol_full;
	logic signed [15:0] wav_s2;
	logic signed [23:0] amp_full;
	logic signed [32:0] pl_full, pr_full;
	logic [15:0]        j45;
	logic [15:0]        sine_sub;
	logic [25:0]        c_calc;
	logic [34:0]        n_full;
	logic [32:0]        c90;
	logic [6:0]         note_sel;
	logic [15:0]        bend_sel;
	logic               bneg;
	logic [16:0]        mag;
	logic signed [9:0]  msum;
	logic [6:0]         mcl;
	logic signed [16:0] pval;
	logic [15:0]        qv;
	logic [3:0]         oct_c;
	logic [11:0]        rem_c;
	logic [52:0]        recip_sum;
	logic [31:0]        base_c;

	assign clearing   = (state_q == ST_CLEAR);
	assign issue      = (state_q == ST_TICK);
	assign cmd_pop    = (state_q == ST_IDLE) && cmd_valid;
	assign tick_start = cmd_pop && (cmd.kind == CMD_TICK);
	assign last_voice = (ti_q == TW'(TRACKS - 1)) && (k_q == KW'(VOICES - 1));
	assign evt_addr   = cmd.vaddr[VA_W-1:0];
	assign cur_addr   = cmd_q.vaddr[VA_W-1:0];
	assign evt_track  = cmd.track[TW-1:0];
	assign rd_addr    = issue ? lin_q : evt_addr;
	assign init_done  = init_done_q;

	// Sine fill arithmetic: c = j * (46080 - 45 j)
	assign j45      = 16'(j_q) * 16'd45;
	assign sine_sub = 16'd46080 - j45;
	assign c_calc   = 26'(j_q) * 26'(sine_sub);
	assign n_full   = 35'(c_q) * 35'd360;
	assign c90      = 33'(c_q) * 33'd90;

	// Bent note to pitch position in 1/256 semitones
	always_comb begin
		note_sel = (cmd_q.kind == CMD_PITCH) ? cmd_q.value[6:0] : note_rd_q;
		bend_sel = (cmd_q.kind == CMD_PITCH) ? bend_rd_q : cmd_q.value;
		bneg     = bend_sel[15];
		mag      = bneg ? (17'h10000 - {1'b0, bend_sel}) : {1'b0, bend_sel};
		msum     = bneg ? ($signed({3'b0, note_sel}) - $signed({1'b0, mag[16:8]}))
		                : ($signed({3'b0, note_sel}) + $signed({1'b0, mag[16:8]}));
		if (msum < 10'sd0) begin
			mcl = 7'd0;
		end else if (msum > 10'sd127) begin
			mcl = 7'd127;
		end else begin
			mcl = msum[6:0];
		end
		pval = bneg ? ($signed({2'b0, mcl, 8'b0}) - $signed({9'b0, mag[7:0]}))
		            : ($signed({2'b0, mcl, 8'b0}) + $signed({9'b0, mag[7:0]}));
		qv   = (pval < 17'sd0) ? NOTE_OFS : (pval[15:0] + NOTE_OFS);
	end

	// Octave and remainder within the octave by comparing against octave bounds
	always_comb begin
		oct_c = 4'd0;
		rem_c = q_q[11:0];
		for (int k = 1; k <= OCT_MAX; k++) begin
			if (q_q >= 16'(k * OCT_SPAN)) begin
				oct_c = 4'(k);
				rem_c = 12'(q_q - 16'(k * OCT_SPAN));
			end
		end
	end

	// Base step from the split reciprocal products
	assign recip_sum = {phi_q, 14'b0} + 53'(plo_q);
	assign base_c    = 32'(recip_sum[52:RECIP_SH]) + STEP_OFS;

	// Divider requests per sequencer state
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		unique case (state_q)
			ST_SIN_D: begin
				div_req.start    = 1'b1;
				div_req.dividend = n_full[31:0];
				div_req.divisor  = SINE_DEN - 18'(c90[32:15]);
			end
			ST_EXP_D: begin
				div_req.start    = 1'b1;
				div_req.dividend = prod_q;
				div_req.divisor  = 18'(kdiv_q);
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	// Memory write ports
	always_comb begin
		phase_we = clearing || v_s1;
		phase_wa = clearing ? clr_q : addr_s1;
		phase_wd = clearing ? '0 : PHASE_W'(phase_s1 + step_s1[PHASE_W-1:0]);

		vel_we   = clearing || (cmd_pop && cmd.kind == CMD_VELOCITY);
		vel_wa   = clearing ? clr_q : evt_addr;
		vel_wd   = clearing ? 7'd0 : cmd.value[6:0];

		evt_wa   = clearing ? clr_q : cur_addr;
		step_we  = clearing || (state_q == ST_BASE_W);
		step_wd  = clearing ? 32'd0 : (base_c << oct_q);
		note_we  = clearing || (state_q == ST_BASE_W && cmd_q.kind == CMD_PITCH);
		note_wd  = clearing ? 7'd0 : cmd_q.value[6:0];
		bend_we  = clearing || (state_q == ST_BASE_W && cmd_q.kind == CMD_BEND);
		bend_wd  = clearing ? 16'd0 : cmd_q.value;

		sine_we  = (state_q == ST_SIN_W) && div_rsp.done;
	end

	// Voice memories with registered reads
	always_ff @(posedge clk) begin
		if (phase_we) begin
			phase_mem_q[phase_wa] <= phase_wd;
		end
		phase_s1 <= phase_mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (step_we) begin
			step_mem_q[evt_wa] <= step_wd;
		end
		step_s1 <= step_mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (vel_we) begin
			vel_mem_q[vel_wa] <= vel_wd;
		end
		vel_s1 <= vel_mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (note_we) begin
			note_mem_q[evt_wa] <= note_wd;
		end
		note_rd_q <= note_mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (bend_we) begin
			bend_mem_q[evt_wa] <= bend_wd;
		end
		bend_rd_q <= bend_mem_q[rd_addr];
	end

	// Sine magnitude for the first half period; sign comes from the index
	always_ff @(posedge clk) begin
		if (sine_we) begin
			sine_mem_q[j_q] <= div_rsp.quot[14:0];
		end
		sine_s2 <= sine_mem_q[idx_s1[9:0]];
	end

	// Stage 1 arithmetic: table index, sawtooth value, pan and volume gains
	always_comb begin
		idx_s1    = phase_s1[PHASE_W-1:16];
		saw_prod  = {idx_s1, 15'b0} - {15'b0, idx_s1};
		saw_val   = $signed({1'b0, saw_prod[25:10]}) - 17'sd32767;
		lpan      = 9'sd63 - {{2{pan_s1[6]}}, pan_s1};
		rpan      = 9'sd63 + {{2{pan_s1[6]}}, pan_s1};
		gain      = 9'sd127 - $signed({2'b0, atten_s1});
		lvol_full = lpan * gain;
		rvol_full = rpan * gain;
	end

	// Stage 2 and 3 arithmetic: amplitude and channel products
	always_comb begin
		if (!tsel_s2) begin
			wav_s2 = $signed(saw_s2);
		end else if (neg_s2) begin
			wav_s2 = -$signed({1'b0, sine_s2});
		end else begin
			wav_s2 = $signed({1'b0, sine_s2});
		end
		amp_full = wav_s2 * $signed({1'b0, vel_s2});
		pl_full  = amp_s3 * lvol_s3;
		pr_full  = amp_s3 * rvol_s3;
	end

	// Mixing pipeline payload
	always_ff @(posedge clk) begin
		addr_s1  <= lin_q;
		tsel_s1  <= table_q[ti_q];
		atten_s1 <= atten_q[ti_q];
		pan_s1   <= pan_q[ti_q];

		tsel_s2  <= tsel_s1;
		neg_s2   <= idx_s1[10];
		saw_s2   <= saw_val[15:0];
		vel_s2   <= vel_s1;
		lvol_s2  <= lvol_full[15:0];
		rvol_s2  <= rvol_full[15:0];

		amp_s3   <= amp_full[23:7];
		lvol_s3  <= lvol_s2;
		rvol_s3  <= rvol_s2;

		pl_s4    <= pl_full[32:14];
		pr_s4    <= pr_full[32:14];
	end

	// Pipeline valids and channel accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			acc_l_q <= '0;
			acc_r_q <= '0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (tick_start) begin
				acc_l_q <= '0;
				acc_r_q <= '0;
			end else if (v_s4) begin
				acc_l_q <= acc_l_q + ACC_W'(pl_s4);
				acc_r_q <= acc_r_q + ACC_W'(pr_s4);
			end
		end
	end

	// Sequencer, track registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			j_q         <= '0;
			c_q         <= '0;
			init_done_q <= 1'b0;
			cmd_q       <= '0;
			lin_q       <= '0;
			ti_q        <= '0;
			k_q         <= '0;
			end_pend_q  <= 1'b0;
			q_q         <= '0;
			oct_q       <= '0;
			rem12_q     <= '0;
			x_q         <= '0;
			e_q         <= '0;
			t_q         <= '0;
			prod_q      <= '0;
			kdiv_q      <= '0;
			m_q         <= '0;
			plo_q       <= '0;
			phi_q       <= '0;
			out_valid_q <= 1'b0;
			left_q      <= '0;
			right_q     <= '0;
			is_end_q    <= 1'b0;
			for (int i = 0; i < TRACKS; i++) begin
				table_q[i] <= 1'b0;
				atten_q[i] <= 7'd0;
				pan_q[i]   <= 7'd0;
			end
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == VA_W'(NVOICE - 1)) begin
						j_q     <= '0;
						state_q <= ST_SIN_C;
					end
				end
				ST_SIN_C: begin
					c_q     <= c_calc;
					state_q <= ST_SIN_D;
				end
				ST_SIN_D: begin
					state_q <= ST_SIN_W;
				end
				ST_SIN_W: begin
					if (div_rsp.done) begin
						j_q <= j_q + 1'b1;
						if (j_q == 10'(SINE_N - 1)) begin
							init_done_q <= 1'b1;
							state_q     <= ST_IDLE;
						end else begin
							state_q <= ST_SIN_C;
						end
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd;
						unique case (cmd.kind)
							CMD_TICK: begin
								lin_q   <= '0;
								ti_q    <= '0;
								k_q     <= '0;
								state_q <= ST_TICK;
							end
							CMD_END: begin
								end_pend_q <= 1'b1;
								state_q    <= ST_OUT;
							end
							CMD_TABLE: begin
								table_q[evt_track] <= cmd.value[0];
							end
							CMD_VOLUME: begin
								atten_q[evt_track] <= cmd.value[6:0];
							end
							CMD_PAN: begin
								pan_q[evt_track] <= cmd.value[6:0];
							end
							CMD_VELOCITY: begin
								state_q <= ST_IDLE;
							end
							CMD_PITCH, CMD_BEND: begin
								state_q <= ST_NRD;
							end
						endcase
					end
				end
				ST_TICK: begin
					lin_q <= lin_q + 1'b1;
					if (k_q == KW'(VOICES - 1)) begin
						k_q  <= '0;
						ti_q <= ti_q + 1'b1;
					end else begin
						k_q <= k_q + 1'b1;
					end
					if (last_voice) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!(v_s1 || v_s2 || v_s3 || v_s4)) begin
						end_pend_q <= 1'b0;
						state_q    <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						is_end_q    <= end_pend_q;
						left_q      <= end_pend_q ? 16'd0 : sat16(acc_l_q);
						right_q     <= end_pend_q ? 16'd0 : sat16(acc_r_q);
						state_q     <= ST_IDLE;
					end
				end
				ST_NRD: begin
					q_q     <= qv;
					state_q <= ST_OCT;
				end
				ST_OCT: begin
					oct_q   <= oct_c;
					rem12_q <= rem_c;
					state_q <= ST_X;
				end
				ST_X: begin
					x_q     <= 32'(rem12_q) * LN_STEP;
					t_q     <= 32'(rem12_q) * LN_STEP;
					e_q     <= '0;
					kdiv_q  <= 8'd2;
					state_q <= ST_EXP;
				end
				ST_EXP: begin
					if (t_q == 32'd0) begin
						m_q     <= 32'(e_q[31:5]) * 32'd22;
						state_q <= ST_BASE;
					end else begin
						e_q     <= e_q + t_q;
						prod_q  <= 32'(t_q[31:13]) * 32'(x_q[31:19]);
						state_q <= ST_EXP_D;
					end
				end
				ST_EXP_D: begin
					state_q <= ST_EXP_W;
				end
				ST_EXP_W: begin
					if (div_rsp.done) begin
						t_q     <= div_rsp.quot;
						kdiv_q  <= kdiv_q + 1'b1;
						state_q <= ST_EXP;
					end
				end
				ST_BASE: begin
					plo_q   <= 40'(m_q[31:6]) * 40'(RECIP_LO);
					phi_q   <= 39'(m_q[31:6]) * 39'(RECIP_HI);
					state_q <= ST_BASE_W;
				end
				ST_BASE_W: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign left_sample  = left_q;
	assign right_sample = right_q;
	assign is_end       = is_end_q;

endmodule

[rtl/core/wavetable_synth_mixer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavetable_synth_mixer_top
// Wavetable synthesizer with stereo mixer: a front end queues classified
// events and ticks, a back end updates voices and mixes one voice a cycle.
// ----------------------------------------------------------------------------
// Tick: the back end issues every voice in turn to the mixing pipeline,
//   waits for the pipeline to drain, then registers the mixed sample.
// Pitch or bend: the phase step comes from an exp series, one divide per term;
//   table, volume, pan and velocity apply in idle. One item at a time; queue of two.
// Reset: a clear of all TRACKS*VOICES voices, then the 1024-entry sine fill;
//   no transaction is accepted before both.
module wavetable_synth_mixer_top #(
	parameter int TRACKS = 16,
	parameter int VOICES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // track_index[3:0], voice_index[6:4], arg[22:7], zero[23]
	input  logic [2:0]  s_tuser,  // mode[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // left_sample[15:0], right_sample[31:16]
	output logic [0:0]  m_tuser   // is_end[0]
);
	import wsm_pkg::*;

	logic     cmd_valid;
	cmd_t     cmd;
	logic     cmd_pop;
	logic     init_done;
	div_req_t div_req;
	div_rsp_t div_rsp;
	logic [15:0] left_sample;
	logic [15:0] right_sample;
	logic        is_end;

	wsm_front #(
		.TRACKS (TRACKS),
		.VOICES (VOICES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.en        (init_done),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	wsm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	wsm_back #(
		.TRACKS (TRACKS),
		.VOICES (VOICES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.init_done    (init_done),
		.div_req      (div_req),
		.div_rsp      (div_rsp),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.is_end       (is_end)
	);

	assign m_tdata = {right_sample, left_sample};
	assign m_tuser = is_end;

endmodule
